// ===== rtl/lzw_encoder_with_reset_defines.svh =====
// assertion macros for the lzw encoder rtl, used by lzw_datapath
// expects signals clk and arst_n in the scope where a macro is used
`ifndef LZW_ENCODER_WITH_RESET_DEFINES_SVH
`define LZW_ENCODER_WITH_RESET_DEFINES_SVH
`ifndef SYNTHESIS
`define LZW_ASSERT(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
	else $error("lzw check failed");
`define LZW_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("lzw check failed");
`else
`define LZW_ASSERT(name, cond)
`define LZW_ASSERT_NEXT(name, pre, post)
`endif
`endif

// ===== rtl/lzw_pkg.sv =====
// shared constants and controller/datapath command and status types
// no dependencies
`timescale 1ns / 1ps
package lzw_pkg;
	localparam int DICT_ENTRIES_DEF = 4096;
	localparam int FIRST_FREE = 256;
	localparam logic [3:0] START_WIDTH = 4'd9;
	localparam logic [3:0] MAX_WIDTH = 4'd15;

	// selects which code a result carries
	localparam logic EMIT_PREFIX = 1'b0;
	localparam logic EMIT_RESET = 1'b1;

	typedef struct packed {
		logic capture;
		logic load_byte;
		logic set_pv;
		logic hash_rd;
		logic next_rd;
		logic code_rd;
		logic hit;
		logic insert;
		logic dict_reset;
		logic restart;
		logic emit;
		logic emit_sel;
		logic emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic pv;
		logic last;
		logic verified;
		logic match;
		logic full;
		logic out_free;
	} dp_stat_t;
endpackage

// ===== rtl/lzw_in_if.sv =====
// input channel: one byte per request with end flag
// no dependencies
`timescale 1ns / 1ps
interface lzw_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic end_of_data;
	modport source (output valid, output data_byte, output end_of_data, input ready);
	modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

// ===== rtl/lzw_out_if.sv =====
// output channel: one code per request with width and last flag
// no dependencies
`timescale 1ns / 1ps
interface lzw_out_if;
	logic valid;
	logic ready;
	logic [11:0] code;
	logic [3:0] code_width;
	logic last_of_run;
	modport source (output valid, output code, output code_width, output last_of_run,
		input ready);
	modport sink (input valid, input code, input code_width, input last_of_run,
		output ready);
endinterface

// ===== rtl/lzw_encoder_with_reset.sv =====
// LZW encoder with dictionary reset, top level
// 
// Input channel din takes one byte per request with an end flag; output
// channel dout gives codes (12 bits), each with its packed width and a flag
// on the final code caused by that byte. A byte yields zero to three codes.
// Bytes are handled one at a time: din is ready only while the controller
// is idle. The first byte of a stream is loaded as the prefix without a table
// lookup. A byte that extends the prefix reads its home slot of the hashed pair
// table, then the code store, then checks the result; each further slot that is
// probed repeats the two reads. A byte that misses then emits its codes one at a
// time. Each probe is two chained reads (pair table, then code store), each
// with a registered read.
// Codes leave through an output register; the next byte is accepted while
// the last code still waits. When dout stalls, the controller waits before
// emitting its next code and holds din not ready.
// Reset returns the encoder to the start of a stream (no prefix, next code
// 256, width 9). The memories need no clearing pass: a table slot only counts
// when its code lies below the next free code and the code store confirms it.
`timescale 1ns / 1ps
module lzw_encoder_with_reset #(
	parameter int DICT_ENTRIES = lzw_pkg::DICT_ENTRIES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	lzw_in_if.sink    din,
	lzw_out_if.source dout
);
	import lzw_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;

	assign din.ready = in_ready;

	// sequencing
	lzw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(din.valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// dictionary and output
	lzw_datapath #(.DICT_ENTRIES(DICT_ENTRIES)) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.data_byte  (din.data_byte),
		.end_of_data(din.end_of_data),
		.dout       (dout)
	);
endmodule

// ===== rtl/lzw_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module lzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held while not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/lzw_ctrl.sv =====
// sequencing state machine for the lzw encoder
// depends on lzw_pkg
`timescale 1ns / 1ps
module lzw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lzw_pkg::dp_stat_t stat,
	output lzw_pkg::dp_cmd_t  cmd
);
	import lzw_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_START    = 3'd1;
	localparam logic [2:0] S_CODE     = 3'd2;
	localparam logic [2:0] S_CHECK    = 3'd3;
	localparam logic [2:0] S_EMIT_PRE = 3'd4;
	localparam logic [2:0] S_EMIT_RST = 3'd5;
	localparam logic [2:0] S_FLUSH    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic [2:0] done_state;

	assign in_ready = (state_q == S_IDLE);
	assign done_state = stat.last ? S_FLUSH : S_IDLE;

	// next state and commands
	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt = S_START;
				end
			end
			S_START: begin
				if (!stat.pv) begin
					cmd.load_byte = 1'b1;
					cmd.set_pv = 1'b1;
					state_nxt = done_state;
				end else begin
					cmd.hash_rd = 1'b1;
					state_nxt = S_CODE;
				end
			end
			S_CODE: begin
				cmd.code_rd = 1'b1;
				state_nxt = S_CHECK;
			end
			S_CHECK: begin
				if (stat.match) begin
					cmd.hit = 1'b1;
					state_nxt = done_state;
				end else if (stat.verified) begin
					cmd.next_rd = 1'b1;
					state_nxt = S_CODE;
				end else begin
					state_nxt = S_EMIT_PRE;
				end
			end
			S_EMIT_PRE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = EMIT_PREFIX;
					cmd.emit_last = !stat.full && !stat.last;
					if (stat.full) begin
						state_nxt = S_EMIT_RST;
					end else begin
						cmd.insert = 1'b1;
						cmd.load_byte = 1'b1;
						state_nxt = done_state;
					end
				end
			end
			S_EMIT_RST: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = EMIT_RESET;
					cmd.emit_last = !stat.last;
					cmd.dict_reset = 1'b1;
					cmd.load_byte = 1'b1;
					state_nxt = done_state;
				end
			end
			S_FLUSH: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = EMIT_PREFIX;
					cmd.emit_last = 1'b1;
					cmd.restart = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end
endmodule

// ===== rtl/lzw_datapath.sv =====
// lzw datapath: prefix state, hashed pair table, code store, output register
// depends on lzw_pkg, lzw_out_if, lzw_ram and the assertion macro header
`timescale 1ns / 1ps
`include "lzw_encoder_with_reset_defines.svh"
module lzw_datapath #(
	parameter int DICT_ENTRIES = lzw_pkg::DICT_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lzw_pkg::dp_cmd_t  cmd,
	output lzw_pkg::dp_stat_t stat,
	input  logic [7:0]        data_byte,
	input  logic              end_of_data,
	lzw_out_if.source         dout
);
	import lzw_pkg::*;

	localparam int CW = $clog2(DICT_ENTRIES);
	localparam int KW = CW + 8;
	localparam int HW = CW + 1;
	localparam logic [CW-1:0] FULL_AT = CW'(DICT_ENTRIES - 1);
	localparam logic [CW-1:0] FIRST_CODE = CW'(FIRST_FREE);
	localparam logic [11:0] CLEAR_CODE = 12'(DICT_ENTRIES - 1);

	logic [7:0]    byte_q;
	logic          last_q;
	logic [CW-1:0] prefix_q;
	logic          pv_q;
	logic [CW-1:0] free_q;
	logic [3:0]    width_q;
	logic [HW-1:0] probe_q;
	logic          out_valid_q;
	logic [11:0]   out_code_q;
	logic [3:0]    out_width_q;
	logic          out_last_q;

	logic [KW-1:0]    key;
	logic [HW-1:0]    hash;
	logic [HW-1:0]    slot_raddr;
	logic [KW+CW-1:0] slot_rdata;
	logic [KW-1:0]    slot_key;
	logic [CW-1:0]    slot_code;
	logic [KW-1:0]    code_rdata;
	logic [CW-1:0]    free_nxt;
	logic [16:0]      grow_lim;
	logic             grow;

	// search key and its home slot
	assign key = {prefix_q, byte_q};
	assign hash = HW'(prefix_q) ^ (HW'(byte_q) << (HW - 8));
	assign slot_raddr = cmd.hash_rd ? hash : probe_q + HW'(1);
	assign slot_key = slot_rdata[KW+CW-1:CW];
	assign slot_code = slot_rdata[CW-1:0];

	// pair table: (key, code) per slot, linear probing
	lzw_ram #(.WIDTH(KW + CW), .DEPTH(2 ** HW)) u_slot_ram (
		.clk  (clk),
		.we   (cmd.insert),
		.waddr(probe_q),
		.wdata({key, free_q}),
		.re   (cmd.hash_rd || cmd.next_rd),
		.raddr(slot_raddr),
		.rdata(slot_rdata)
	);

	// code store: key of each assigned code, confirms slots of this epoch
	lzw_ram #(.WIDTH(KW), .DEPTH(2 ** CW)) u_code_ram (
		.clk  (clk),
		.we   (cmd.insert),
		.waddr(free_q),
		.wdata(key),
		.re   (cmd.code_rd),
		.raddr(slot_code),
		.rdata(code_rdata)
	);

	// slot holds a live entry when its code is assigned and maps back to its key
	assign stat.verified = (slot_code >= FIRST_CODE) && (slot_code < free_q) &&
		(code_rdata == slot_key);
	assign stat.match = stat.verified && (slot_key == key);
	assign stat.full = (free_q >= FULL_AT);
	assign stat.pv = pv_q;
	assign stat.last = last_q;
	assign stat.out_free = !out_valid_q || dout.ready;

	// width growth after an insert
	assign free_nxt = free_q + CW'(1);
	assign grow_lim = 17'(1) << width_q;
	assign grow = (width_q < MAX_WIDTH) && (17'(free_nxt) > grow_lim);

	// captured byte and probe address
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= data_byte;
			last_q <= end_of_data;
		end
		if (cmd.hash_rd || cmd.next_rd) begin
			probe_q <= slot_raddr;
		end
	end

	// encoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
			pv_q <= 1'b0;
			free_q <= FIRST_CODE;
			width_q <= START_WIDTH;
		end else if (cmd.restart) begin
			prefix_q <= '0;
			pv_q <= 1'b0;
			free_q <= FIRST_CODE;
			width_q <= START_WIDTH;
		end else begin
			if (cmd.load_byte) begin
				prefix_q <= CW'(byte_q);
			end else if (cmd.hit) begin
				prefix_q <= slot_code;
			end
			if (cmd.set_pv) begin
				pv_q <= 1'b1;
			end
			if (cmd.dict_reset) begin
				free_q <= FIRST_CODE;
				width_q <= START_WIDTH;
			end else if (cmd.insert) begin
				free_q <= free_nxt;
				if (grow) begin
					width_q <= width_q + 4'd1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_code_q <= (cmd.emit_sel == EMIT_RESET) ? CLEAR_CODE : 12'(prefix_q);
			out_width_q <= width_q;
			out_last_q <= cmd.emit_last;
		end
	end

	assign dout.valid = out_valid_q;
	assign dout.code = out_code_q;
	assign dout.code_width = out_width_q;
	assign dout.last_of_run = out_last_q;

	`LZW_ASSERT(a_free_range, (free_q >= FIRST_CODE) && (free_q <= FULL_AT))
	`LZW_ASSERT(a_insert_room, !(cmd.insert && stat.full))
	`LZW_ASSERT(a_emit_room, !(cmd.emit && out_valid_q && !dout.ready))
	`LZW_ASSERT_NEXT(a_restart, cmd.restart, !pv_q && (free_q == FIRST_CODE))
endmodule

// ===== test/tb_lzw_encoder_with_reset.sv =====
// testbench for the lzw encoder: drives bytes on din, checks codes on dout
// against an in-bench dictionary model; depends on lzw_pkg, the channel interfaces and the encoder
`timescale 1ns / 1ps
module tb_lzw_encoder_with_reset;
	import lzw_pkg::*;

	localparam int DICT_DEPTH = DICT_ENTRIES_DEF;
	localparam logic [11:0] CLEAR_CODE = 12'(DICT_DEPTH - 1);
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [11:0] code;
		logic [3:0] width;
		logic last;
	} code_rec_t;

	logic clk;
	logic arst_n;
	lzw_in_if din ();
	lzw_out_if dout ();

	lzw_encoder_with_reset #(.DICT_ENTRIES(DICT_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.din(din.sink),
		.dout(dout.source)
	);

	// dictionary model state
	logic [11:0] pair_prefix [DICT_DEPTH];
	logic [7:0] pair_byte [DICT_DEPTH];
	int pair_lookup [int];
	logic [11:0] cur_prefix;
	logic have_prefix;
	int model_free;
	logic [3:0] cur_width;

	code_rec_t codes_due [$];
	int err_count;
	int idle_pct;
	int stall_pct;
	longint cycles;

	// clock and cycle limit
	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	function automatic void push_code(input logic [11:0] c);
		code_rec_t r;
		r.code = c;
		r.width = cur_width;
		r.last = 1'b0;
		codes_due.push_back(r);
	endfunction

	function automatic void restart_stream();
		cur_prefix = '0;
		have_prefix = 1'b0;
		model_free = FIRST_FREE;
		cur_width = START_WIDTH;
	endfunction

	// expected codes for one accepted byte
	function automatic void encode_byte(input logic [7:0] b, input logic eod);
		int n_before;
		int key;
		int c;
		logic hit;
		n_before = codes_due.size();
		hit = 1'b0;
		key = int'(cur_prefix) * 256 + int'(b);
		if (!have_prefix) begin
			cur_prefix = 12'(b);
			have_prefix = 1'b1;
		end else begin
			if (pair_lookup.exists(key)) begin
				c = pair_lookup[key];
				if (c >= FIRST_FREE && c < model_free && pair_prefix[c] == cur_prefix
						&& pair_byte[c] == b)
					hit = 1'b1;
			end
			if (hit) begin
				cur_prefix = 12'(c);
			end else begin
				push_code(cur_prefix);
				if (model_free >= int'(CLEAR_CODE)) begin
					// dictionary full: reset code, then start over
					push_code(CLEAR_CODE);
					model_free = FIRST_FREE;
					cur_width = START_WIDTH;
				end else begin
					pair_prefix[model_free] = cur_prefix;
					pair_byte[model_free] = b;
					pair_lookup[key] = model_free;
					model_free++;
					if (cur_width < MAX_WIDTH && model_free > (1 << cur_width))
						cur_width++;
				end
				cur_prefix = 12'(b);
			end
		end
		if (eod) begin
			push_code(cur_prefix);
			restart_stream();
		end
		if (codes_due.size() > n_before)
			codes_due[codes_due.size() - 1].last = 1'b1;
	endfunction

	// send one byte request and predict its codes on acceptance
	task automatic send_byte(input logic [7:0] b, input logic eod);
		while ($urandom_range(99) < idle_pct) begin
			din.valid = 1'b0;
			@(negedge clk);
		end
		din.valid = 1'b1;
		din.data_byte = b;
		din.end_of_data = eod;
		do @(posedge clk); while (!din.ready);
		encode_byte(b, eod);
		@(negedge clk);
		din.valid = 1'b0;
	endtask

	// receiver stalls
	always @(negedge clk) begin
		if (!arst_n)
			dout.ready <= 1'b0;
		else
			dout.ready <= ($urandom_range(99) >= stall_pct);
	end

	// compare each delivered code with the oldest expectation
	always @(posedge clk) begin
		code_rec_t want;
		if (arst_n && dout.valid && dout.ready) begin
			if (codes_due.size() == 0) begin
				report_mismatch("unexpected code", int'(dout.code), -1);
			end else begin
				want = codes_due.pop_front();
				if (dout.code !== want.code)
					report_mismatch("code", int'(dout.code), int'(want.code));
				if (dout.code_width !== want.width)
					report_mismatch("code_width", int'(dout.code_width), int'(want.width));
				if (dout.last_of_run !== want.last)
					report_mismatch("last_of_run", int'(dout.last_of_run), int'(want.last));
			end
		end
	end

	task automatic drain();
		while (codes_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_stream(input int len, input int alphabet);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(alphabet - 1)), i == len - 1);
	endtask

	// extremes, single-byte streams, repeats that extend the prefix
	task automatic test_directed();
		send_byte(8'd0, 1'b1);
		send_byte(8'd255, 1'b1);
		send_byte(8'd0, 1'b0);
		send_byte(8'd255, 1'b0);
		send_byte(8'd0, 1'b0);
		send_byte(8'd255, 1'b1);
		for (int i = 0; i < 10; i++)
			send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b1);
		drain();
	endtask

	// one long stream until the code width steps past its start value
	task automatic test_width_growth();
		int guard;
		guard = 0;
		while (cur_width == START_WIDTH && guard < 600) begin
			send_byte(8'($urandom_range(255)), 1'b0);
			guard++;
		end
		for (int i = 0; i < 3; i++)
			send_byte(8'($urandom_range(255)), 1'b0);
		send_byte(8'($urandom_range(255)), 1'b1);
		drain();
	endtask

	// random streams; small alphabets give prefix hits
	task automatic test_random(input int n_items, input int idle, input int stall);
		int sent;
		int len;
		int alpha;
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? 1 : $urandom_range(20, 2);
			case ($urandom_range(2))
				0: alpha = 2;
				1: alpha = 4;
				default: alpha = 256;
			endcase
			if ($urandom_range(7) == 0) begin
				// noise: single stray bytes with random end flags
				send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
				sent++;
			end else begin
				send_stream(len, alpha);
				sent += len;
			end
		end
		drain();
	endtask

	initial begin
		err_count = 0;
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		restart_stream();
		arst_n = 1'b0;
		din.valid = 1'b0;
		din.data_byte = '0;
		din.end_of_data = 1'b0;
		dout.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_width_growth();
		test_random(12, 0, 0);
		test_random(12, 75, 0);
		test_random(12, 0, 75);
		test_random(12, 18, 18);

		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lzw_pkg.sv
rtl/lzw_in_if.sv
rtl/lzw_out_if.sv
rtl/lzw_ram.sv
rtl/lzw_ctrl.sv
rtl/lzw_datapath.sv
rtl/lzw_encoder_with_reset.sv
test/tb_lzw_encoder_with_reset.sv
